/* rtl/tds_median_compensated_meter_unit_macros.svh */
// Assertion macros for the TDS meter top level.
// No dependencies.
`ifndef TDS_MEDIAN_COMPENSATED_METER_UNIT_MACROS_SVH
`define TDS_MEDIAN_COMPENSATED_METER_UNIT_MACROS_SVH
// implication checked every clock, quiet in reset
`define TDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/tds_pkg.sv */
// Shared types and constants for the TDS meter.
// No dependencies.
`default_nettype none
package tds_pkg;
  localparam int unsigned SAMPLE_COUNT_DEF = 32;
  localparam int unsigned MV_W  = 12;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned TMP_W = 11;
  localparam int unsigned TDS_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 2'd2;
  localparam logic [CNT_W-1:0] SAMPLE_IV_RST = 16'd40;
  localparam logic [CNT_W-1:0] REPORT_IV_RST = 16'd800;
  localparam logic [TMP_W-1:0] TEMP_RST      = 11'd250;
  localparam logic [23:0] COEF_A = 24'd8743813;
  localparam logic [23:0] COEF_B = 24'd16768041;
  localparam logic [25:0] COEF_C = 26'd56189911;
  localparam logic [19:0] VOLT_MAX = 20'hFFFFF;
  // front -> back: one report request
  typedef struct packed {
    logic [MV_W-1:0] median;
  } tds_job_t;
endpackage
`default_nettype wire

/* rtl/tds_median_compensated_meter_unit.sv */
// Top level of the median filtered, temperature compensated TDS meter.
// Depends on tds_pkg, tds_front, tds_queue, tds_back and the macros header.
//
//  channel | ports                               | role
//  in      | in_valid/in_ready, in_adc_millivolts | one millisecond tick
//  out     | out_valid/out_ready, out_*           | one TDS result
//  cfg     | cfg_we, cfg_index, cfg_data          | interval and temperature writes
//
// A tick that starts no report leaves the front ready. A report tick holds the
// front while the median is found by rank counting over the ring's single read
// port, longer if the queue is full; the back then runs a bit-serial divide plus
// five multiplier steps from taking the job to offering the result.
// Reset is synchronous; ring contents are not cleared. Both sides stall apart
// through a two-entry queue; the result sits in an output register.
`default_nettype none
module tds_median_compensated_meter_unit #(
  parameter int unsigned SampleCount = tds_pkg::SAMPLE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tds_pkg::MV_W-1:0]      in_adc_millivolts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tds_pkg::MV_W-1:0]           out_median_millivolts,
  output logic [tds_pkg::TDS_W-1:0]          out_tds_tenths_ppm,
  output logic                               out_tds_saturated,
  input  wire logic                          cfg_we,
  input  wire logic [tds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tds_pkg::CNT_W-1:0]     cfg_data
);
  import tds_pkg::*;
  `include "tds_median_compensated_meter_unit_macros.svh"

  logic [CNT_W-1:0] sample_iv_r, report_iv_r;
  logic [TMP_W-1:0] temp_r;
  logic fq_v, fq_r, qb_v, qb_r;
  tds_job_t fq_d, qb_d;

  // configuration registers; unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_iv_r <= SAMPLE_IV_RST; report_iv_r <= REPORT_IV_RST; temp_r <= TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE: sample_iv_r <= cfg_data;
        REG_REPORT: report_iv_r <= cfg_data;
        REG_TEMP:   temp_r <= cfg_data[TMP_W-1:0];
        default: ;
      endcase
    end
  end

  tds_front #(.SampleCount(SampleCount)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_adc(in_adc_millivolts),
    .sample_iv(sample_iv_r), .report_iv(report_iv_r),
    .job_valid(fq_v), .job_ready(fq_r), .job(fq_d));

  tds_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_v), .wr_ready(fq_r), .wr_data(fq_d),
    .rd_valid(qb_v), .rd_ready(qb_r), .rd_data(qb_d));

  tds_back u_back (
    .clk, .rst_n, .job_valid(qb_v), .job_ready(qb_r), .job(qb_d), .temp(temp_r),
    .out_valid, .out_ready, .out_median(out_median_millivolts),
    .out_tds(out_tds_tenths_ppm), .out_sat(out_tds_saturated));

  `TDS_ASSERT_IMP(a_sat_max, out_valid && out_tds_saturated, out_tds_tenths_ppm == 16'hFFFF, "saturated item not at maximum")
  `TDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tds_tenths_ppm), "result dropped while stalled")
  `TDS_ASSERT_IMP(a_job_hold, fq_v && !fq_r, !in_ready, "front took an item with a job pending")
endmodule
`default_nettype wire

/* rtl/tds_front.sv */
// Front: tick counters, sample ring and serial median search.
// Depends on tds_pkg.
`default_nettype none
module tds_front #(
  parameter int unsigned SampleCount = tds_pkg::SAMPLE_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [tds_pkg::MV_W-1:0]  in_adc,
  input  wire logic [tds_pkg::CNT_W-1:0] sample_iv,
  input  wire logic [tds_pkg::CNT_W-1:0] report_iv,
  output logic                           job_valid,
  input  wire logic                      job_ready,
  output tds_pkg::tds_job_t              job
);
  import tds_pkg::*;
  localparam int unsigned IW = (SampleCount > 1) ? $clog2(SampleCount) : 1;
  localparam int unsigned CW = $clog2(SampleCount + 1);
  localparam logic [CW-1:0] LO_RANK = CW'((SampleCount - 1) / 2);
  localparam logic [CW-1:0] HI_RANK = CW'(SampleCount / 2);
  localparam logic [IW-1:0] LAST = IW'(SampleCount - 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_NEXT, S_OUT} st_t;
  st_t st_r;
  logic [MV_W-1:0] ring [SampleCount];
  logic [IW-1:0] wpos_r, ci_r, cj_r;
  logic full_r;
  logic [CNT_W-1:0] se_r, re_r;
  logic [MV_W-1:0] rd_r, cand_r, lo_r, hi_r;
  logic [CW-1:0] less_r, leq_r;
  logic lo_ok_r, hi_ok_r;
  logic last_r;
  logic [MV_W-1:0] rd_med;
  logic [CNT_W:0] se_n, re_n;
  logic s_fire, r_fire;
  logic [MV_W:0] msum;

  // candidate holds rank k when less <= k < leq (final entry included)
  function automatic logic lo_cnt_hit(input logic [CW-1:0] less, input logic [CW-1:0] leq,
                                      input logic [MV_W-1:0] x, input logic [MV_W-1:0] c,
                                      input logic [CW-1:0] k);
    logic [CW-1:0] l2, q2;
    l2 = less + ((x < c) ? 1'b1 : 1'b0);
    q2 = leq + ((x <= c) ? 1'b1 : 1'b0);
    return (l2 <= k) && (k < q2);
  endfunction

  assign in_ready = (st_r == S_IDLE);
  assign se_n = {1'b0, se_r} + 1'b1;
  assign re_n = {1'b0, re_r} + 1'b1;
  assign s_fire = se_n > {1'b0, sample_iv};
  assign r_fire = re_n > {1'b0, report_iv};
  assign msum = {1'b0, lo_r} + {1'b0, hi_r};
  assign job_valid = (st_r == S_OUT);
  assign job.median = (SampleCount % 2 == 1) ? lo_r : msum[MV_W:1];

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && s_fire) ring[wpos_r] <= in_adc;
    rd_med <= ring[cj_r];
  end

  // rank search: each candidate i counts entries below / not above it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wpos_r <= '0; full_r <= 1'b0; se_r <= '0; re_r <= '0;
      ci_r <= '0; cj_r <= '0; lo_ok_r <= 1'b0; hi_ok_r <= 1'b0; last_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            se_r <= s_fire ? '0 : se_n[CNT_W-1:0];
            re_r <= r_fire ? '0 : re_n[CNT_W-1:0];
            if (s_fire) begin
              wpos_r <= (wpos_r == LAST) ? '0 : wpos_r + 1'b1;
              if (wpos_r == LAST) full_r <= 1'b1;
            end
            if (r_fire && (full_r || (s_fire && wpos_r == LAST))) begin
              st_r <= S_RD; ci_r <= '0; cj_r <= '0;
              lo_ok_r <= 1'b0; hi_ok_r <= 1'b0;
            end
          end
        end
        S_RD: begin
          // candidate read issued at ci; scan restarts from entry zero
          cj_r <= '0;
          st_r <= S_CMP;
        end
        S_CMP: begin
          cand_r <= rd_med; less_r <= '0; leq_r <= '0;
          last_r <= (cj_r == LAST);
          if (cj_r != LAST) cj_r <= cj_r + 1'b1;
          st_r <= S_NEXT;
        end
        S_NEXT: begin
          // rd_med holds the registered read of the previously addressed entry
          if (rd_med < cand_r) less_r <= less_r + 1'b1;
          if (rd_med <= cand_r) leq_r <= leq_r + 1'b1;
          if (!last_r) begin
            last_r <= (cj_r == LAST);
            if (cj_r != LAST) cj_r <= cj_r + 1'b1;
          end else begin
            if (!lo_ok_r && lo_cnt_hit(less_r, leq_r, rd_med, cand_r, LO_RANK)) begin
              lo_r <= cand_r; lo_ok_r <= 1'b1;
            end
            if (!hi_ok_r && lo_cnt_hit(less_r, leq_r, rd_med, cand_r, HI_RANK)) begin
              hi_r <= cand_r; hi_ok_r <= 1'b1;
            end
            if (ci_r != LAST) begin
              ci_r <= ci_r + 1'b1; cj_r <= ci_r + 1'b1; st_r <= S_RD;
            end else begin
              cj_r <= '0; st_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (job_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/tds_queue.sv */
// Two-entry queue between front and back.
// Depends on tds_pkg.
`default_nettype none
module tds_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  tds_pkg::tds_job_t      wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output tds_pkg::tds_job_t      rd_data
);
  import tds_pkg::*;
  tds_job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

/* rtl/tds_back.sv */
// Back: serial divide, cubic on one shared multiplier, output register.
// Depends on tds_pkg.
`default_nettype none
module tds_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      job_valid,
  output logic                           job_ready,
  input  tds_pkg::tds_job_t              job,
  input  wire logic [tds_pkg::TMP_W-1:0] temp,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [tds_pkg::MV_W-1:0]       out_median,
  output logic [tds_pkg::TDS_W-1:0]      out_tds,
  output logic                           out_sat
);
  import tds_pkg::*;
  typedef enum logic [3:0] {B_IDLE, B_DIV, B_V2, B_V3, B_PA, B_PB, B_PC, B_PS, B_T, B_OUT} st_t;
  st_t st_r;
  logic [MV_W-1:0] med_r;
  logic [11:0] d_r;
  logic [28:0] num_r;
  logic [12:0] rem_r;
  logic [28:0] q_r;
  logic [4:0] k_r;
  logic [19:0] v_r;
  logic [27:0] v2_r;
  logic [35:0] v3_r;
  logic [63:0] prod_r;
  logic signed [66:0] poly_r;
  logic [12:0] rem_sh;
  logic signed [12:0] dt;
  logic [12:0] rem_sub;

  assign job_ready = (st_r == B_IDLE);
  assign dt = 13'sd500 + 13'(signed'({temp[TMP_W-1], temp, 1'b0}));
  assign rem_sh = {rem_r[11:0], num_r[28]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        B_IDLE: if (job_valid) begin
          med_r <= job.median;
          d_r <= (dt < 13'sd1) ? 12'd1 : dt[11:0];
          num_r <= {1'b0, job.median, 16'd0} + 29'(((dt < 13'sd1) ? 12'd1 : dt[11:0]) >> 1);
          rem_r <= '0; q_r <= '0; k_r <= '0; st_r <= B_DIV;
        end
        B_DIV: begin
          // restoring divide, one quotient bit a cycle
          num_r <= {num_r[27:0], 1'b0};
          if (rem_sh >= {1'b0, d_r}) begin
            rem_r <= rem_sub; q_r <= {q_r[27:0], 1'b1};
          end else begin
            rem_r <= rem_sh; q_r <= {q_r[27:0], 1'b0};
          end
          if (k_r == 5'd28) st_r <= B_V2;
          k_r <= k_r + 1'b1;
        end
        B_V2: begin
          v_r <= (q_r > 29'(VOLT_MAX)) ? VOLT_MAX : q_r[19:0];
          st_r <= B_V3;
        end
        B_V3: begin
          prod_r <= 64'(v_r) * 64'(v_r);
          st_r <= B_PA;
        end
        B_PA: begin
          v2_r <= 28'((prod_r + 64'h8000) >> 16);
          prod_r <= 64'(28'((prod_r + 64'h8000) >> 16)) * 64'(v_r);
          st_r <= B_PB;
        end
        B_PB: begin
          v3_r <= 36'((prod_r + 64'h8000) >> 16);
          prod_r <= 64'(v2_r) * 64'(COEF_B);
          st_r <= B_PC;
        end
        B_PC: begin
          poly_r <= -67'(signed'({3'b0, prod_r}));
          prod_r <= 64'(v3_r) * 64'(COEF_A);
          st_r <= B_PS;
        end
        B_PS: begin
          poly_r <= poly_r + 67'(signed'({3'b0, prod_r}));
          prod_r <= 64'(v_r) * 64'(COEF_C);
          st_r <= B_T;
        end
        B_T: begin
          logic signed [66:0] p;
          logic [66:0] tn;
          p = poly_r + 67'(signed'({3'b0, prod_r}));
          if (p < 0) p = '0;
          poly_r <= p;
          tn = ({p[64:0], 2'b00} + 67'(p) + 67'h80000000) >> 32;
          out_median <= med_r;
          out_sat <= tn > 67'd65535;
          out_tds <= (tn > 67'd65535) ? 16'hFFFF : tn[15:0];
          out_valid <= 1'b1;
          st_r <= B_OUT;
        end
        B_OUT: if (out_ready) begin
          out_valid <= 1'b0; st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Testbench for the median filtered, temperature compensated TDS meter.
// Depends on tds_pkg and the tds_median_compensated_meter_unit RTL.
// Self-checking: an in-bench TDS predictor plus a scoreboard queue of results.
`default_nettype none
module testbench;
  import tds_pkg::*;

  localparam int unsigned RING_N = 32;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register at this index
  localparam int unsigned STALL_LIMIT = 20000;  // cycles with nothing accepted
  localparam int unsigned SETTLE_CYCLES = 2500;  // one report through median and back

  typedef struct {
    logic [MV_W-1:0]  median;
    logic [TDS_W-1:0] tds;
    logic             sat;
  } tds_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MV_W-1:0] in_adc_millivolts = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MV_W-1:0] out_median_millivolts;
  logic [TDS_W-1:0] out_tds_tenths_ppm;
  logic out_tds_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  tds_median_compensated_meter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_adc_millivolts(in_adc_millivolts),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_median_millivolts(out_median_millivolts),
    .out_tds_tenths_ppm(out_tds_tenths_ppm), .out_tds_saturated(out_tds_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the block's registers and state
  logic [CNT_W-1:0] sample_iv, report_iv;
  logic [TMP_W-1:0] temp_reg;
  logic [MV_W-1:0]  ring [RING_N];
  int unsigned      wr_pos;
  bit               filled;
  int unsigned      sample_cnt, report_cnt;

  tds_result_t expected_tds[$];
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned quiet_cycles = 0;

  // one interval counter: fires when elapsed+1 exceeds the interval
  function automatic bit counter_fires(ref int unsigned elapsed, input logic [CNT_W-1:0] iv);
    int unsigned nxt;
    nxt = (elapsed & 32'hFFFF) + 1;
    if (nxt > iv) begin
      elapsed = 0;
      return 1'b1;
    end
    elapsed = nxt;
    return 1'b0;
  endfunction

  function automatic int unsigned window_median();
    int unsigned s [RING_N];
    int unsigned t;
    for (int i = 0; i < RING_N; i++) s[i] = ring[i];
    for (int i = 0; i < RING_N; i++)
      for (int j = 0; j < RING_N - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    return (s[RING_N/2] + s[RING_N/2 - 1]) / 2;  // even count: truncated mean
  endfunction

  // advance the predictor by one tick; queue a result if a report fires on a full window
  task automatic predict_tick(input logic [MV_W-1:0] adc);
    tds_result_t r;
    int unsigned med;
    longint temp, d, v, v2, v3, poly, tenths;
    if (counter_fires(sample_cnt, sample_iv)) begin
      ring[wr_pos] = adc;
      wr_pos++;
      if (wr_pos >= RING_N) begin
        wr_pos = 0;
        filled = 1'b1;
      end
    end
    if (!counter_fires(report_cnt, report_iv) || !filled) return;
    med = window_median();
    temp = longint'($signed(temp_reg));
    d = 500 + 2 * temp;
    if (d < 1) d = 1;  // coefficient at or below zero
    v = (longint'(med) * 65536 + d / 2) / d;
    if (v > longint'(VOLT_MAX)) v = longint'(VOLT_MAX);
    v2 = (v * v + 32768) >>> 16;
    v3 = (v2 * v + 32768) >>> 16;
    poly = longint'(COEF_A) * v3 - longint'(COEF_B) * v2 + longint'(COEF_C) * v;
    if (poly < 0) poly = 0;
    tenths = (poly * 5 + 64'h8000_0000) >>> 32;
    r.median = med[MV_W-1:0];
    r.sat = tenths > 65535;
    r.tds = r.sat ? 16'hFFFF : tenths[TDS_W-1:0];
    expected_tds.push_back(r);
  endtask

  // send one tick; leaves valid high unless an idle gap is drawn
  task automatic send_tick(input logic [MV_W-1:0] adc);
    int unsigned gap;
    in_valid <= 1'b1;
    in_adc_millivolts <= adc;
    do @(posedge clk); while (!in_ready);
    predict_tick(adc);
    ticks_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE: sample_iv = val;
      REG_REPORT: report_iv = val;
      REG_TEMP:   temp_reg = val[TMP_W-1:0];
      default: begin
      end
    endcase
  endtask

  // all expected items in, then let any report still in the median finish
  task automatic wait_idle();
    while (expected_tds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk) begin
    if (hold_request != 0) begin
      out_ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tds.size() == 0) begin
        $error("unexpected result: median %0d tds %0d", out_median_millivolts,
               out_tds_tenths_ppm);
        errors++;
      end else begin
        tds_result_t e;
        e = expected_tds.pop_front();
        results_seen++;
        if (e.sat) sat_seen++;
        if (out_median_millivolts !== e.median) begin
          $error("median_millivolts: expected %0d, got %0d", e.median, out_median_millivolts);
          errors++;
        end
        if (out_tds_tenths_ppm !== e.tds) begin
          $error("tds_tenths_ppm: expected %0d, got %0d", e.tds, out_tds_tenths_ppm);
          errors++;
        end
        if (out_tds_saturated !== e.sat) begin
          $error("tds_saturated: expected %0d, got %0d", e.sat, out_tds_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles in which nothing is accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // sample every tick, report every tick: extremes of the reading and window fill
  task automatic test_extremes();
    write_reg(REG_SAMPLE, 16'd0);
    write_reg(REG_REPORT, 16'd0);
    for (int i = 0; i < 16; i++) send_tick(12'd4095);
    for (int i = 0; i < 16; i++) send_tick(12'd0);
    send_tick(12'hAAA);
    send_tick(12'h555);
    end_burst();
    wait_idle();
  endtask

  // temperature extremes, including coefficient clamped at one
  task automatic test_temperature();
    logic signed [TMP_W-1:0] temps [7];
    temps = '{-11'sd100, 11'sd850, -11'sd250, -11'sd300, 11'sd1023, 11'sh400, 11'sd250};
    foreach (temps[k]) begin
      write_reg(REG_TEMP, {{(CNT_W-TMP_W){temps[k][TMP_W-1]}}, temps[k]});
      repeat (3) send_tick(12'($urandom_range(4095)));
      send_tick(12'd4095);
      end_burst();
      wait_idle();
    end
  endtask

  // a write to an unused index must change nothing
  task automatic test_unused_index();
    write_reg(REG_UNUSED, 16'hFFFF);
    repeat (4) send_tick(12'($urandom_range(4095)));
    end_burst();
    wait_idle();
  endtask

  // widest intervals: nothing fires for a while, then back to short ones
  task automatic test_long_intervals();
    write_reg(REG_SAMPLE, 16'hFFFF);
    write_reg(REG_REPORT, 16'hFFFF);
    repeat (20) send_tick(12'($urandom_range(4095)));
    end_burst();
    wait_idle();
    write_reg(REG_SAMPLE, 16'd1);
    write_reg(REG_REPORT, 16'd2);
    repeat (12) send_tick(12'($urandom_range(4095)));
    end_burst();
    wait_idle();
  endtask

  // receiver held off long enough that the queue fills and input stalls
  task automatic test_backpressure();
    write_reg(REG_SAMPLE, 16'd0);
    write_reg(REG_REPORT, 16'd0);
    send_idle_pct = 0;
    hold_request = 9000;
    repeat (8) send_tick(12'($urandom_range(4095)));
    end_burst();
    wait_idle();  // sender pauses until every result is in
  endtask

  // random readings under random short intervals and temperatures, per idling phase
  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_ticks);
    int unsigned left;
    int unsigned burst;
    logic [MV_W-1:0] base;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    left = n_ticks;
    while (left > 0) begin
      write_reg(REG_SAMPLE, 16'($urandom_range(3)));
      write_reg(REG_REPORT, 16'($urandom_range(10)));
      write_reg(REG_TEMP, 16'($urandom_range(1023) - 200));
      burst = (left < 40) ? left : 40;
      base = 12'($urandom_range(4095));
      repeat (burst) begin
        // mostly readings clustered round a level, now and then a wild one
        if ($urandom_range(9) == 0) send_tick(12'($urandom_range(4095)));
        else send_tick(base ^ 12'($urandom_range(63)));
      end
      left -= burst;
      end_burst();
      wait_idle();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    sample_iv = SAMPLE_IV_RST;
    report_iv = REPORT_IV_RST;
    temp_reg = TEMP_RST;
    wr_pos = 0;
    filled = 1'b0;
    sample_cnt = 0;
    report_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_temperature();
    test_unused_index();
    test_long_intervals();
    test_backpressure();
    test_random(0, 0, 120);
    test_random(70, 0, 120);
    test_random(0, 70, 120);
    test_random(18, 18, 120);
    $display("covered %0d ticks and %0d TDS results (%0d saturated)", ticks_sent,
             results_seen, sat_seen);
    $display("intervals and temperatures at their extremes, four idling phases");
    if (errors == 0 && expected_tds.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
